[hdl/ctc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the contiguous transfer coalescer.
// Used by the result queue, the top level and the port checker; depends on nothing.
package ctc_pkg;

	typedef enum logic [1:0] {
		KIND_OTHER = 2'd0,
		KIND_LD    = 2'd1,
		KIND_LMV   = 2'd2,
		KIND_LLDI  = 2'd3
	} kind_t;

	localparam int IN_TDATA_W  = 176;
	localparam int IN_TUSER_W  = 4;
	localparam int OUT_TDATA_W = 208;
	localparam int OUT_TUSER_W = 3;
	localparam int FIELD_W     = 32;
	localparam int ECOUNT_W    = 16;
	localparam int OINDEX_W    = 16;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		kind_t                kind;
		logic                 bias;
		logic [FIELD_W-1:0]   src_addr;
		logic [FIELD_W-1:0]   src_offset;
		logic [FIELD_W-1:0]   dst_addr;
		logic [FIELD_W-1:0]   dst_offset;
		logic [ECOUNT_W-1:0]  count;
		logic [FIELD_W-1:0]   tag;
		logic                 first;
		logic                 last;
	} instr_t;

	typedef struct packed {
		kind_t                kind;
		logic                 bias;
		logic [FIELD_W-1:0]   src_addr;
		logic [FIELD_W-1:0]   src_offset;
		logic [FIELD_W-1:0]   dst_addr;
		logic [FIELD_W-1:0]   dst_offset;
		logic [FIELD_W-1:0]   count;
		logic [FIELD_W-1:0]   tag;
		logic [OINDEX_W-1:0]  index;
		logic                 last;
	} result_t;

	typedef struct packed {
		logic en0;
		logic en1;
	} push_t;

endpackage

[hdl/ctc_result_queue.sv]
`timescale 1ns / 1ps
// Four-entry result queue that takes up to two results per cycle and gives one.
// Depends on ctc_pkg for the result and push types.
module ctc_result_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  ctc_pkg::push_t     push,
	input  ctc_pkg::result_t   data0,
	input  ctc_pkg::result_t   data1,
	input  logic               pop,
	output logic               room2,
	output logic               out_valid,
	output ctc_pkg::result_t   out_data
);

	ctc_pkg::result_t                  entry_q [ctc_pkg::QUEUE_DEPTH];
	logic [ctc_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [ctc_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [ctc_pkg::QCNT_W-1:0]        count_q;
	logic [ctc_pkg::QPTR_W-1:0]        wr_ptr_nx;
	logic [ctc_pkg::QCNT_W-1:0]        n_push;
	logic                              do_pop;

	assign wr_ptr_nx = wr_ptr_q + ctc_pkg::QPTR_W'(1);
	assign n_push    = ctc_pkg::QCNT_W'(push.en0) + ctc_pkg::QCNT_W'(push.en1);
	assign do_pop    = pop && out_valid;
	assign out_valid = count_q != '0;
	assign out_data  = entry_q[rd_ptr_q];
	assign room2     = count_q <= ctc_pkg::QCNT_W'(ctc_pkg::QUEUE_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.en0) begin
			entry_q[wr_ptr_q] <= data0;
		end
		if (push.en1) begin
			entry_q[wr_ptr_nx] <= data1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + ctc_pkg::QPTR_W'(n_push);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + ctc_pkg::QPTR_W'(1);
			end
			count_q <= count_q + n_push - ctc_pkg::QCNT_W'(do_pop);
		end
	end

endmodule

[hdl/contiguous_transfer_coalescer.sv]
`timescale 1ns / 1ps
// Top level of the contiguous transfer coalescer: input register, merge logic,
// pending register and result queue. Depends on ctc_pkg and ctc_result_queue.
//
//  Channel  | Direction | Signals                              | Contents
//  ---------+-----------+--------------------------------------+--------------------------
//  s_axis   | in        | tvalid tready tdata[175:0] tuser tlast| transfer instructions
//  m_axis   | out       | tvalid tready tdata[207:0] tuser tlast| coalesced instructions
//  cfg      | in        | cfg_valid cfg_ready cfg_data         | batch_mode register
//
// One instruction is accepted per cycle while the input register is empty or advancing.
// It is captured in the input register and is then merged into the pending run or
// emitted to the result queue. An instruction gives at most two results; the input
// register advances only while the four-entry queue holds two results or fewer, so a
// stalled output holds off the input once three or four results wait. Reset clears
// the pending run, the index, the queue and sets batch_mode to 1.
module contiguous_transfer_coalescer #(
	parameter int ADDR_BITS  = 32,
	parameter int INDEX_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// src_addr, src_offset, dst_addr, dst_offset, elem_count, payload_tag
	input  logic [ctc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// op_kind[1:0], is_bias, stream_first
	input  logic [ctc_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// out_src_addr, out_src_offset, out_dst_addr, out_dst_offset, out_count,
	// out_tag, out_index
	output logic [ctc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// out_kind[1:0], out_bias
	output logic [ctc_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
	output logic                                m_axis_tlast,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_data
);

	localparam int AW    = (ADDR_BITS < ctc_pkg::FIELD_W) ? ADDR_BITS : ctc_pkg::FIELD_W;
	localparam int SUM_W = ctc_pkg::FIELD_W + 1;

	logic                      batch_mode_q;
	ctc_pkg::instr_t           in_s1;
	logic                      valid_s1;
	logic                      advance;
	logic                      room2;

	logic                      pend_valid_q;
	ctc_pkg::kind_t            pend_kind_q;
	logic                      pend_bias_q;
	logic [AW-1:0]             pend_src_addr_q;
	logic [AW-1:0]             pend_src_offset_q;
	logic [AW-1:0]             pend_dst_addr_q;
	logic [AW-1:0]             pend_dst_offset_q;
	logic [ctc_pkg::FIELD_W-1:0] pend_count_q;
	logic [ctc_pkg::FIELD_W-1:0] pend_tag_q;
	logic [INDEX_BITS-1:0]     emit_index_q;

	logic [AW-1:0]             sa;
	logic [AW-1:0]             so;
	logic [AW-1:0]             da;
	logic [AW-1:0]             dof;
	logic [SUM_W-1:0]          sum_sa;
	logic [SUM_W-1:0]          sum_so;
	logic [SUM_W-1:0]          sum_da;
	logic [SUM_W-1:0]          sum_do;
	logic [SUM_W-1:0]          sum_cnt;
	logic                      pv_eff;
	logic                      flush_first;
	logic                      contig;
	logic                      merge;
	logic                      emit_mid;
	logic [INDEX_BITS-1:0]     idx_base;
	logic [INDEX_BITS-1:0]     idx_after;

	logic [ctc_pkg::FIELD_W-1:0] new_count;
	ctc_pkg::result_t          res_pend;
	ctc_pkg::result_t          res_new;
	ctc_pkg::result_t          data0;
	ctc_pkg::push_t            push;
	ctc_pkg::result_t          out_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_mode_q <= 1'b1;
		end else if (cfg_valid) begin
			batch_mode_q <= cfg_data;
		end
	end

	assign advance       = valid_s1 && room2;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			in_s1.kind       <= ctc_pkg::kind_t'(s_axis_tuser[1:0]);
			in_s1.bias       <= s_axis_tuser[2];
			in_s1.first      <= s_axis_tuser[3];
			in_s1.src_addr   <= s_axis_tdata[31:0];
			in_s1.src_offset <= s_axis_tdata[63:32];
			in_s1.dst_addr   <= s_axis_tdata[95:64];
			in_s1.dst_offset <= s_axis_tdata[127:96];
			in_s1.count      <= s_axis_tdata[143:128];
			in_s1.tag        <= s_axis_tdata[175:144];
			in_s1.last       <= s_axis_tlast;
		end
	end

	assign sa  = in_s1.src_addr[AW-1:0];
	assign so  = in_s1.src_offset[AW-1:0];
	assign da  = in_s1.dst_addr[AW-1:0];
	assign dof = in_s1.dst_offset[AW-1:0];

	assign sum_sa  = SUM_W'(pend_src_addr_q) + SUM_W'(pend_count_q);
	assign sum_so  = SUM_W'(pend_src_offset_q) + SUM_W'(pend_count_q);
	assign sum_da  = SUM_W'(pend_dst_addr_q) + SUM_W'(pend_count_q);
	assign sum_do  = SUM_W'(pend_dst_offset_q) + SUM_W'(pend_count_q);
	assign sum_cnt = SUM_W'(pend_count_q) + SUM_W'(in_s1.count);

	assign flush_first = in_s1.first && pend_valid_q;
	assign pv_eff      = pend_valid_q && !in_s1.first;

	always_comb begin
		contig = 1'b0;
		if (pv_eff && in_s1.kind == pend_kind_q) begin
			unique case (in_s1.kind)
				ctc_pkg::KIND_LD: begin
					if (!in_s1.bias) begin
						if (batch_mode_q) begin
							contig = sa == pend_src_addr_q && sum_so == SUM_W'(so) &&
								da == pend_dst_addr_q && sum_do == SUM_W'(dof);
						end else begin
							contig = sa == pend_src_addr_q && sum_so == SUM_W'(so) &&
								sum_da == SUM_W'(da) && dof == pend_dst_offset_q;
						end
					end
				end
				ctc_pkg::KIND_LMV: begin
					contig = sum_sa == SUM_W'(sa) && so == pend_src_offset_q &&
						da == pend_dst_addr_q && sum_do == SUM_W'(dof);
				end
				ctc_pkg::KIND_LLDI: begin
					contig = da == pend_dst_addr_q && sum_do == SUM_W'(dof);
				end
				ctc_pkg::KIND_OTHER: begin
					contig = 1'b0;
				end
				default: begin
					contig = 1'b0;
				end
			endcase
		end
	end

	assign merge     = contig && !sum_cnt[SUM_W-1];
	assign emit_mid  = pv_eff && !merge;
	assign idx_base  = in_s1.first ? '0 : emit_index_q;
	assign idx_after = idx_base + INDEX_BITS'(emit_mid);
	assign new_count = merge ? sum_cnt[ctc_pkg::FIELD_W-1:0]
		: ctc_pkg::FIELD_W'(in_s1.count);

	always_comb begin
		res_pend.kind       = pend_kind_q;
		res_pend.bias       = pend_bias_q;
		res_pend.src_addr   = ctc_pkg::FIELD_W'(pend_src_addr_q);
		res_pend.src_offset = ctc_pkg::FIELD_W'(pend_src_offset_q);
		res_pend.dst_addr   = ctc_pkg::FIELD_W'(pend_dst_addr_q);
		res_pend.dst_offset = ctc_pkg::FIELD_W'(pend_dst_offset_q);
		res_pend.count      = pend_count_q;
		res_pend.tag        = pend_tag_q;
		res_pend.index      = ctc_pkg::OINDEX_W'(emit_index_q);
		res_pend.last       = flush_first;

		res_new       = res_pend;
		res_new.count = new_count;
		res_new.index = ctc_pkg::OINDEX_W'(idx_after);
		res_new.last  = 1'b1;
		if (!merge) begin
			res_new.kind       = in_s1.kind;
			res_new.bias       = in_s1.bias;
			res_new.src_addr   = ctc_pkg::FIELD_W'(sa);
			res_new.src_offset = ctc_pkg::FIELD_W'(so);
			res_new.dst_addr   = ctc_pkg::FIELD_W'(da);
			res_new.dst_offset = ctc_pkg::FIELD_W'(dof);
			res_new.tag        = in_s1.tag;
		end
	end

	assign push.en0 = advance && (flush_first || emit_mid || in_s1.last);
	assign push.en1 = advance && in_s1.last && (flush_first || emit_mid);
	assign data0    = (flush_first || emit_mid) ? res_pend : res_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			emit_index_q <= '0;
		end else if (advance) begin
			pend_valid_q <= !in_s1.last;
			emit_index_q <= in_s1.last ? '0 : idx_after;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pend_count_q <= new_count;
			if (!merge) begin
				pend_kind_q       <= in_s1.kind;
				pend_bias_q       <= in_s1.bias;
				pend_src_addr_q   <= sa;
				pend_src_offset_q <= so;
				pend_dst_addr_q   <= da;
				pend_dst_offset_q <= dof;
				pend_tag_q        <= in_s1.tag;
			end
		end
	end

	ctc_result_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.data0     (data0),
		.data1     (res_new),
		.pop       (m_axis_tready),
		.room2     (room2),
		.out_valid (m_axis_tvalid),
		.out_data  (out_res)
	);

	assign m_axis_tdata = {out_res.index, out_res.tag, out_res.count, out_res.dst_offset,
		out_res.dst_addr, out_res.src_offset, out_res.src_addr};
	assign m_axis_tuser = {out_res.bias, out_res.kind};
	assign m_axis_tlast = out_res.last;

endmodule

[hdl/ctc_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the contiguous transfer coalescer, bound to the top level.
// Depends on ctc_pkg for the channel widths.
module ctc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_axis_tready,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [ctc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input logic [ctc_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
	input logic                               m_axis_tlast
);

	logic m_xfer;

	assign m_xfer = m_axis_tvalid && m_axis_tready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("Result withdrawn while stalled.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			$stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("Result changed while stalled.");

	a_back_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("Input held off with no result waiting.");

	a_index_restart: assert property (@(posedge clk) disable iff (!arst_n)
		m_xfer && m_axis_tlast ##1 m_xfer |-> m_axis_tdata[207:192] == 16'd0)
		else $error("Index did not restart after the final result of a stream.");

endmodule

bind contiguous_transfer_coalescer ctc_checker u_ctc_checker (.*);
